>>> rtl/dpc_pkg.sv
package dpc_pkg;

  // Counter range of the column and row position counters
  localparam int unsigned CNT_WIDTH = 12;
  localparam int unsigned CNT_LIMIT = 4096;

  // Size of the queue between the front and the back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned DEF_MAX_LINE_WIDTH   = 4096;
  localparam int unsigned DEF_MAX_FRAME_HEIGHT = 4096;

  // Register reset values
  localparam logic [23:0] RST_INV_FOCAL_X  = 24'd45599;
  localparam logic [23:0] RST_INV_FOCAL_Y  = 24'd45599;
  localparam logic [15:0] RST_CENTER_X     = 16'd4067;
  localparam logic [15:0] RST_CENTER_Y     = 16'd3268;
  localparam logic [12:0] RST_LINE_WIDTH   = 13'd512;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd424;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Offset magnitude (Q.4), product widths
  localparam int unsigned MAG_WIDTH   = 17;
  localparam int unsigned PROD1_WIDTH = MAG_WIDTH + 24;
  localparam int unsigned PROD2_WIDTH = PROD1_WIDTH + 16;
  localparam int unsigned FRAC_BITS   = 28;

  typedef enum logic [2:0] {
    CFG_INV_FOCAL_X  = 3'd0,
    CFG_INV_FOCAL_Y  = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_LINE_WIDTH   = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [12:0] line_width;
    logic [12:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
    logic [15:0]        z_mm;
    logic               point_valid;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
    logic [7:0]         alpha_out;
    logic               row_end;
    logic               frame_end;
  } point_t;

  // Classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [MAG_WIDTH-1:0] mag_x;
    logic                 neg_x;
    logic [MAG_WIDTH-1:0] mag_y;
    logic                 neg_y;
    logic [15:0]          depth;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic                 row_end;
    logic                 frame_end;
  } work_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [QCNT_WIDTH-1:0] count;
  } queue_stat_t;

endpackage

>>> rtl/depth_pixel_to_point_cloud_top.sv
// Depth pixel to point cloud back-projection, pinhole camera model.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per depth
// pixel in raster order, depth in mm plus BGR colour. Output channel
// (out_valid_o/out_ready_i/out_data_o): exactly one point per pixel, in order,
// with X/Y/Z in mm, colour, alpha and row/frame end marks. Zero depth gives
// an invalid point with all coordinates and colour zero.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
// ready; write registers only while no pixel is in flight.
// Each pixel passes the queue, then the two-stage multiplier pipeline in the back
// end (offset times inverse focal length, then times depth). Throughput: one
// pixel per cycle while the receiver does not stall the output.
// The front end holds the column/row counters and classifies each pixel; a
// 4-entry queue decouples it from the back end. When the receiver stalls, the
// back end holds its pipeline and the front keeps accepting until the queue
// fills. Reset clears counters, the queue and the pipeline valids, and loads
// the default camera intrinsics and a 512x424 frame.
module depth_pixel_to_point_cloud_top #(
  parameter int unsigned MAX_LINE_WIDTH   = dpc_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned MAX_FRAME_HEIGHT = dpc_pkg::DEF_MAX_FRAME_HEIGHT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [23:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dpc_pkg::pixel_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dpc_pkg::point_t out_data_o
);

  dpc_pkg::cfg_t        cfg_q, cfg_d;
  dpc_pkg::work_t       push_entry, pop_entry;
  dpc_pkg::queue_stat_t qstat;
  logic                 push, pop;

  // Configuration registers: always take the write
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dpc_pkg::CFG_INV_FOCAL_X:  cfg_d.inv_focal_x  = cfg_data_i;
        dpc_pkg::CFG_INV_FOCAL_Y:  cfg_d.inv_focal_y  = cfg_data_i;
        dpc_pkg::CFG_CENTER_X:     cfg_d.center_x     = cfg_data_i[15:0];
        dpc_pkg::CFG_CENTER_Y:     cfg_d.center_y     = cfg_data_i[15:0];
        dpc_pkg::CFG_LINE_WIDTH:   cfg_d.line_width   = cfg_data_i[12:0];
        dpc_pkg::CFG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i[12:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_focal_x  <= dpc_pkg::RST_INV_FOCAL_X;
      cfg_q.inv_focal_y  <= dpc_pkg::RST_INV_FOCAL_Y;
      cfg_q.center_x     <= dpc_pkg::RST_CENTER_X;
      cfg_q.center_y     <= dpc_pkg::RST_CENTER_Y;
      cfg_q.line_width   <= dpc_pkg::RST_LINE_WIDTH;
      cfg_q.frame_height <= dpc_pkg::RST_FRAME_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: position counters and offset classification
  dpc_front #(
    .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
    .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .queue_full_i(qstat.full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Decoupling queue
  dpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .stat_o (qstat)
  );

  // Back end: multiply, round, output register
  dpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .queue_empty_i(qstat.empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= dpc_pkg::QCNT_WIDTH'(dpc_pkg::QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // An invalid point carries no coordinates, no alpha and no blue colour
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.point_valid) |->
      (out_data_o.x_mm == 32'sd0 && out_data_o.y_mm == 32'sd0 &&
       out_data_o.z_mm == 16'd0 && out_data_o.alpha_out == 8'd0 &&
       out_data_o.blue_out == 8'd0))
    else $error("invalid point with nonzero payload");

  // A valid point is opaque and has depth
  a_valid_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.point_valid) |->
      (out_data_o.alpha_out == dpc_pkg::ALPHA_OPAQUE && out_data_o.z_mm != 16'd0))
    else $error("valid point not opaque or zero depth");

  // The last pixel of a frame is also the last pixel of a row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |-> out_data_o.row_end)
    else $error("frame end without row end");

endmodule

>>> rtl/dpc_front.sv
module dpc_front #(
  parameter int unsigned MAX_LINE_WIDTH   = dpc_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned MAX_FRAME_HEIGHT = dpc_pkg::DEF_MAX_FRAME_HEIGHT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpc_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dpc_pkg::pixel_t in_data_i,
  input  logic           queue_full_i,
  output logic           push_o,
  output dpc_pkg::work_t entry_o
);

  localparam int unsigned WLIM =
    (MAX_LINE_WIDTH < dpc_pkg::CNT_LIMIT) ? MAX_LINE_WIDTH : dpc_pkg::CNT_LIMIT;
  localparam int unsigned HLIM =
    (MAX_FRAME_HEIGHT < dpc_pkg::CNT_LIMIT) ? MAX_FRAME_HEIGHT : dpc_pkg::CNT_LIMIT;
  localparam logic [12:0] WLIM_V = 13'(WLIM);
  localparam logic [12:0] HLIM_V = 13'(HLIM);

  logic [dpc_pkg::CNT_WIDTH-1:0] col_q, col_d, row_q, row_d;
  logic [12:0] w_eff, h_eff;
  logic [dpc_pkg::CNT_WIDTH-1:0] last_col, last_row;
  logic rend, fend, accept;
  logic signed [17:0] diff_x, diff_y;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // Clamp the frame size to at least one and to the counter range
  always_comb begin
    if (cfg_i.line_width == 13'd0) begin
      w_eff = 13'd1;
    end else if (cfg_i.line_width > WLIM_V) begin
      w_eff = WLIM_V;
    end else begin
      w_eff = cfg_i.line_width;
    end
    if (cfg_i.frame_height == 13'd0) begin
      h_eff = 13'd1;
    end else if (cfg_i.frame_height > HLIM_V) begin
      h_eff = HLIM_V;
    end else begin
      h_eff = cfg_i.frame_height;
    end
  end

  assign last_col = dpc_pkg::CNT_WIDTH'(w_eff - 13'd1);
  assign last_row = dpc_pkg::CNT_WIDTH'(h_eff - 13'd1);
  assign rend     = col_q >= last_col;
  assign fend     = rend && (row_q >= last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (rend) begin
        col_d = '0;
        row_d = fend ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Signed Q.4 offset from the principal point, split into sign and magnitude
  assign diff_x = $signed({2'b00, col_q, 4'b0000}) - $signed({2'b00, cfg_i.center_x});
  assign diff_y = $signed({2'b00, row_q, 4'b0000}) - $signed({2'b00, cfg_i.center_y});

  always_comb begin
    entry_o.neg_x     = diff_x[17];
    entry_o.neg_y     = diff_y[17];
    entry_o.mag_x     = dpc_pkg::MAG_WIDTH'(diff_x[17] ? -diff_x : diff_x);
    entry_o.mag_y     = dpc_pkg::MAG_WIDTH'(diff_y[17] ? -diff_y : diff_y);
    entry_o.depth     = in_data_i.depth_mm;
    entry_o.blue      = in_data_i.blue_in;
    entry_o.green     = in_data_i.green_in;
    entry_o.red       = in_data_i.red_in;
    entry_o.row_end   = rend;
    entry_o.frame_end = fend;
  end

endmodule

>>> rtl/dpc_queue.sv
module dpc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dpc_pkg::work_t      entry_i,
  input  logic                pop_i,
  output dpc_pkg::work_t      entry_o,
  output dpc_pkg::queue_stat_t stat_o
);

  dpc_pkg::work_t mem [dpc_pkg::QUEUE_DEPTH];

  logic [dpc_pkg::QPTR_WIDTH-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [dpc_pkg::QCNT_WIDTH-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.count = cnt_q;
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.full  = cnt_q == dpc_pkg::QCNT_WIDTH'(dpc_pkg::QUEUE_DEPTH);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/dpc_back.sv
module dpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpc_pkg::cfg_t  cfg_i,
  input  logic           queue_empty_i,
  input  dpc_pkg::work_t entry_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dpc_pkg::point_t out_data_o
);

  localparam int unsigned P1 = dpc_pkg::PROD1_WIDTH;
  localparam int unsigned P2 = dpc_pkg::PROD2_WIDTH;
  localparam int unsigned RW = P2 + 1 - dpc_pkg::FRAC_BITS;
  localparam logic [P2:0] ROUND_HALF = (P2 + 1)'(1) << (dpc_pkg::FRAC_BITS - 1);

  logic adv;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  // Stage 1: offset times inverse focal length
  logic [P1-1:0]  s1_px_q, s1_py_q;
  dpc_pkg::work_t s1_q;
  // Stage 2: times depth
  logic [P2-1:0]  s2_px_q, s2_py_q;
  dpc_pkg::work_t s2_q;

  logic [P2:0]    sum_x, sum_y;
  logic [RW-1:0]  r_x, r_y;
  dpc_pkg::point_t out_d, out_q;

  // Advance the whole pipe unless a finished point waits at the output
  assign adv         = !out_valid_q || out_ready_i;
  assign pop_o       = adv && !queue_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !queue_empty_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= entry_i;
      s1_px_q <= P1'(entry_i.mag_x) * P1'(cfg_i.inv_focal_x);
      s1_py_q <= P1'(entry_i.mag_y) * P1'(cfg_i.inv_focal_y);
      s2_q    <= s1_q;
      s2_px_q <= P2'(s1_px_q) * P2'(s1_q.depth);
      s2_py_q <= P2'(s1_py_q) * P2'(s1_q.depth);
      out_q   <= out_d;
    end
  end

  // Round half away from zero on the magnitude; the result stays below 2^30,
  // so the signed 32-bit range is never exceeded
  assign sum_x = {1'b0, s2_px_q} + ROUND_HALF;
  assign sum_y = {1'b0, s2_py_q} + ROUND_HALF;
  assign r_x   = sum_x[P2:dpc_pkg::FRAC_BITS];
  assign r_y   = sum_y[P2:dpc_pkg::FRAC_BITS];

  always_comb begin
    out_d           = '0;
    out_d.row_end   = s2_q.row_end;
    out_d.frame_end = s2_q.frame_end;
    if (s2_q.depth != 16'd0) begin
      out_d.x_mm        = s2_q.neg_x ? -$signed(32'(r_x)) : $signed(32'(r_x));
      out_d.y_mm        = s2_q.neg_y ? -$signed(32'(r_y)) : $signed(32'(r_y));
      out_d.z_mm        = s2_q.depth;
      out_d.point_valid = 1'b1;
      out_d.blue_out    = s2_q.blue;
      out_d.green_out   = s2_q.green;
      out_d.red_out     = s2_q.red;
      out_d.alpha_out   = dpc_pkg::ALPHA_OPAQUE;
    end
  end

endmodule
